[hdl/assert_macros.svh]
// Assertion macros used by the positional_array_list RTL.
// Bodies collapse to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define PAL_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("positional list assertion failed");

// when ante holds, cons must hold in the following cycle
`define PAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list assertion failed");

`else

`define PAL_ASSERT(lbl, clk, rst_n, expr)
`define PAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/pal_pkg.sv]
// Shared types and constants for the positional list.
// Used by pal_cell, pal_reduce and positional_array_list.
`default_nettype none

package pal_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int LEN_W        = 8;
    localparam int GROUP_SIZE   = 16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic              shift_up;
        logic              shift_down;
        logic [POS_W-1:0]  pos_ix;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/pal_cell.sv]
// One storage cell of the list chain; shifts with its neighbors on insert/delete.
// Depends on pal_pkg.
`default_nettype none

module pal_cell #(
    parameter int IDX = 0
) (
    input  wire logic                       aclk,
    input  wire pal_pkg::cell_ctrl_t        ctrl,
    input  wire logic [pal_pkg::DATA_W-1:0] left_data,
    input  wire logic [pal_pkg::DATA_W-1:0] right_data,
    output logic      [pal_pkg::DATA_W-1:0] data,
    output logic      [pal_pkg::DATA_W-1:0] hit_data
);
    import pal_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_pos;
    logic              past_pos;

    assign at_pos   = {24'd0, ctrl.pos_ix} == 32'(IDX);
    assign past_pos = {24'd0, ctrl.pos_ix} <  32'(IDX);

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_up) begin
            if (at_pos) begin
                data_next = ctrl.value;
            end else if (past_pos) begin
                data_next = left_data;
            end
        end else if (ctrl.shift_down) begin
            if (at_pos || past_pos) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign hit_data = at_pos ? data_reg : '0;

endmodule

`default_nettype wire

[hdl/pal_reduce.sv]
// Two-level OR tree that collects the one selected cell value.
// Group results are registered on load. Depends on pal_pkg.
`default_nettype none

module pal_reduce #(
    parameter int N     = pal_pkg::DEF_CAPACITY,
    parameter int GROUP = pal_pkg::GROUP_SIZE
) (
    input  wire logic                       aclk,
    input  wire logic                       load,
    input  wire logic [pal_pkg::DATA_W-1:0] in_data [N],
    output logic      [pal_pkg::DATA_W-1:0] out_data
);
    import pal_pkg::*;

    localparam int NG = (N + GROUP - 1) / GROUP;

    logic [DATA_W-1:0] term      [NG][GROUP];
    logic [DATA_W-1:0] group_or  [NG];
    logic [DATA_W-1:0] group_reg [NG];

    for (genvar g = 0; g < NG; g++) begin : g_grp
        for (genvar j = 0; j < GROUP; j++) begin : g_term
            if (g * GROUP + j < N) begin : g_live
                assign term[g][j] = in_data[g * GROUP + j];
            end else begin : g_pad
                assign term[g][j] = '0;
            end
        end

        always_comb begin
            group_or[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                group_or[g] = group_or[g] | term[g][j];
            end
        end

        always_ff @(posedge aclk) begin
            if (load) begin
                group_reg[g] <= group_or[g];
            end
        end
    end

    always_comb begin
        out_data = '0;
        for (int g = 0; g < NG; g++) begin
            out_data = out_data | group_reg[g];
        end
    end

endmodule

`default_nettype wire

[hdl/positional_array_list.sv]
// Positional list of CAPACITY 32-bit entries held in a chain of cells, addressed by
// 1-based position. Insert shifts later entries up, delete returns the entry and
// shifts later entries down, read returns the entry. Each item gives one result with
// status, value and length. An item passes through GATHER and DONE before its result
// reaches the output register; DONE waits while an earlier result is untaken, and the
// next item is accepted only back in IDLE. The registered OR tree picks the addressed
// cell in GATHER before the chain shifts. No clearing pass after reset.
// Depends on pal_pkg, pal_cell, pal_reduce and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module positional_array_list #(
    parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_cmd,
    input  wire logic [pal_pkg::POS_W-1:0]         s_position,
    input  wire logic signed [pal_pkg::DATA_W-1:0] s_value_in,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_status,
    output logic signed [pal_pkg::DATA_W-1:0]      m_value_out,
    output logic [pal_pkg::LEN_W-1:0]              m_list_length
);
    import pal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    status_t           status_reg, status_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_value_reg, m_value_next;
    logic [LEN_W-1:0]  m_len_reg, m_len_next;

    logic              accept;
    logic              apply;
    logic              ins_pos_ok;
    logic              rd_pos_ok;
    logic              is_full;
    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] picked;
    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] hit_data  [CAPACITY];

    assign accept = s_valid && s_ready;
    assign apply  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    assign ins_pos_ok = (s_position != '0) && (VW'(s_position) <= VW'(count_reg) + VW'(1));
    assign rd_pos_ok  = (s_position != '0) && (VW'(s_position) <= VW'(count_reg));
    assign is_full    = count_reg == CW'(CAPACITY);

    assign ctrl.shift_up   = apply && status_reg == ST_OK && cmd_reg == CMD_INSERT;
    assign ctrl.shift_down = apply && status_reg == ST_OK && cmd_reg == CMD_DELETE;
    assign ctrl.pos_ix     = pos_reg - POS_W'(1);
    assign ctrl.value      = val_reg;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (k == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_left
            assign left_d = cell_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_right
            assign right_d = cell_data[k+1];
        end
        pal_cell #(
            .IDX(k)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .left_data (left_d),
            .right_data(right_d),
            .data      (cell_data[k]),
            .hit_data  (hit_data[k])
        );
    end

    pal_reduce #(
        .N    (CAPACITY),
        .GROUP(GROUP_SIZE)
    ) u_reduce (
        .aclk    (aclk),
        .load    (state_reg == S_GATHER),
        .in_data (hit_data),
        .out_data(picked)
    );

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_len_next    = m_len_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next   = cmd_t'(s_cmd);
                    pos_next   = s_position;
                    val_next   = s_value_in;
                    state_next = S_GATHER;
                    case (s_cmd) inside
                        CMD_INSERT: begin
                            status_next = !ins_pos_ok ? ST_BADPOS :
                                          (is_full ? ST_FULL : ST_OK);
                        end
                        CMD_DELETE, CMD_READ: begin
                            status_next = rd_pos_ok ? ST_OK : ST_BADPOS;
                        end
                        default: begin
                            status_next = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_GATHER: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (apply) begin
                    if (ctrl.shift_up) begin
                        count_next = count_reg + CW'(1);
                    end else if (ctrl.shift_down) begin
                        count_next = count_reg - CW'(1);
                    end
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_value_next  = (status_reg == ST_OK && cmd_reg != CMD_INSERT) ?
                                    picked : '0;
                    m_len_next    = LEN_W'(count_next);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_len_reg    <= m_len_next;
    end

    assign s_ready       = state_reg == S_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_value_out   = m_value_reg;
    assign m_list_length = m_len_reg;

    `PAL_ASSERT(a_count_cap, aclk, aresetn, count_reg <= CW'(CAPACITY))
    `PAL_ASSERT(a_err_zero, aclk, aresetn, !m_valid || m_status == ST_OK || m_value_out == '0)
    `PAL_ASSERT_NEXT(a_ins_count, aclk, aresetn, ctrl.shift_up, count_reg == $past(count_reg) + CW'(1))
    `PAL_ASSERT_NEXT(a_del_count, aclk, aresetn, ctrl.shift_down, count_reg == $past(count_reg) - CW'(1))
    `PAL_ASSERT_NEXT(a_accept_seq, aclk, aresetn, accept, state_reg == S_GATHER && !s_ready)

endmodule

`default_nettype wire
